[src/aeprq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the active/expired priority run-queue unit.
// No dependencies; the queue control, the top level and the testbench import this package.
package aeprq_pkg;

	localparam int LEVELS_DEF      = 9;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;

	localparam int OPC_W   = 3;
	localparam int TID_W   = 8;
	localparam int PRI_W   = 4;
	localparam int ETIME_W = 16;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 9;
	localparam int THR_W   = 16;

	localparam logic [THR_W-1:0] THRESH_RESET = 16'd20;

	typedef enum logic [OPC_W-1:0] {
		OP_ADD_ACTIVE  = 3'd0,
		OP_ADD_EXPIRED = 3'd1,
		OP_TAKE        = 3'd2,
		OP_SWAP        = 3'd3,
		OP_RETIRE      = 3'd4,
		OP_CLEAR_ACT   = 3'd5
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [TID_W-1:0]   oid;
		logic [PRI_W-1:0]   opri;
		status_t            st;
		logic [COUNT_W-1:0] total;
		logic [COUNT_W-1:0] active;
		logic               from_ram;
	} aeprq_res_t;

endpackage

[src/aeprq_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module aeprq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 288
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/aeprq_qctl.sv]
`timescale 1ns / 1ps
// Queue control: head, tail and fill per queue, bank select, thread counters and
// the level encoder for takes. Depends on aeprq_pkg; drives the entry RAM ports.
module aeprq_qctl import aeprq_pkg::*; #(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ID_BITS_DEF,
	localparam int ID_W       = (ID_BITS < TID_W) ? ID_BITS : TID_W,
	localparam int ADDR_W     = $clog2(2 * LEVELS * QUEUE_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  opcode_t             op,
	input  logic [TID_W-1:0]    thread_id,
	input  logic [PRI_W-1:0]    priority_req,
	input  logic [ETIME_W-1:0]  exec_time,
	input  logic [THR_W-1:0]    demote_threshold,
	output aeprq_res_t          res,
	output logic                ram_we,
	output logic [ADDR_W-1:0]   ram_waddr,
	output logic [ID_W-1:0]     ram_wdata,
	output logic                ram_re,
	output logic [ADDR_W-1:0]   ram_raddr
);

	localparam int NQ        = 2 * LEVELS;
	localparam int Q_W       = $clog2(NQ);
	localparam int LVL_W     = $clog2(LEVELS);
	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
	localparam int CAPACITY  = NQ * QUEUE_DEPTH;
	localparam int COUNT_CAP = (CAPACITY < 511) ? CAPACITY : 511;

	logic [PTR_W-1:0]   head_q [NQ];
	logic [PTR_W-1:0]   tail_q [NQ];
	logic [FILL_W-1:0]  fill_q [NQ];
	logic               bank_q;
	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] active_q;

	logic [LVL_W-1:0]   lvl_sat;
	logic [LVL_W-1:0]   lvl_exp;
	logic               demote;
	logic [LEVELS-1:0]  act_ne;
	logic [LVL_W-1:0]   take_lvl;
	logic               take_any;
	logic [LVL_W-1:0]   lvl_sel;
	logic               bank_sel;
	logic [Q_W-1:0]     q_sel;
	logic [FILL_W-1:0]  fill_sel;
	logic               full;
	logic               push_ok;
	logic               pop_ok;
	logic [COUNT_W-1:0] total_inc;
	logic [COUNT_W-1:0] active_inc;
	logic [COUNT_W-1:0] total_dec;
	logic [COUNT_W-1:0] active_dec;
	logic [COUNT_W-1:0] total_nx;
	logic [COUNT_W-1:0] active_nx;
	logic               bank_nx;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign lvl_sat = ({1'b0, priority_req} >= 5'(LEVELS)) ? LVL_W'(LEVELS - 1)
		: priority_req[LVL_W-1:0];
	assign demote  = (exec_time > demote_threshold) &&
		({{(5 - LVL_W){1'b0}}, lvl_sat} <= 5'(LEVELS - 2));
	assign lvl_exp = demote ? lvl_sat + 1'b1 : lvl_sat;

	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			act_ne[i] = bank_q ? (fill_q[LEVELS + i] != '0) : (fill_q[i] != '0);
		end
	end

	always_comb begin
		take_lvl = '0;
		take_any = 1'b0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (act_ne[i]) begin
				take_lvl = LVL_W'(i);
				take_any = 1'b1;
			end
		end
	end

	always_comb begin
		case (op)
			OP_ADD_EXPIRED: begin
				lvl_sel  = lvl_exp;
				bank_sel = ~bank_q;
			end
			OP_TAKE: begin
				lvl_sel  = take_lvl;
				bank_sel = bank_q;
			end
			default: begin
				lvl_sel  = lvl_sat;
				bank_sel = bank_q;
			end
		endcase
	end

	assign q_sel    = bank_sel ? Q_W'(LEVELS) + Q_W'(lvl_sel) : Q_W'(lvl_sel);
	assign fill_sel = fill_q[q_sel];
	assign full     = (fill_sel == FILL_W'(QUEUE_DEPTH));
	assign push_ok  = ((op == OP_ADD_ACTIVE) || (op == OP_ADD_EXPIRED)) && !full;
	assign pop_ok   = (op == OP_TAKE) && take_any;

	assign ram_we    = fire && push_ok;
	assign ram_waddr = ADDR_W'(q_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[q_sel]);
	assign ram_wdata = thread_id[ID_W-1:0];
	assign ram_re    = fire && pop_ok;
	assign ram_raddr = ADDR_W'(q_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[q_sel]);

	assign total_inc  = (total_q < COUNT_W'(COUNT_CAP)) ? total_q + 1'b1 : total_q;
	assign active_inc = (active_q < COUNT_W'(COUNT_CAP)) ? active_q + 1'b1 : active_q;
	assign total_dec  = (total_q != '0) ? total_q - 1'b1 : '0;
	assign active_dec = (active_q != '0) ? active_q - 1'b1 : '0;

	always_comb begin
		total_nx  = total_q;
		active_nx = active_q;
		bank_nx   = bank_q;
		res.oid      = TID_W'(thread_id[ID_W-1:0]);
		res.opri     = '0;
		res.st       = ST_OK;
		res.from_ram = 1'b0;
		case (op)
			OP_ADD_ACTIVE: begin
				res.opri = PRI_W'(lvl_sat);
				if (push_ok) begin
					total_nx  = total_inc;
					active_nx = active_inc;
				end else begin
					res.st = ST_FULL;
				end
			end
			OP_ADD_EXPIRED: begin
				res.opri  = PRI_W'(lvl_exp);
				active_nx = active_dec;
				if (!push_ok) begin
					res.st = ST_FULL;
				end
			end
			OP_TAKE: begin
				if (take_any) begin
					res.opri     = PRI_W'(take_lvl);
					res.from_ram = 1'b1;
				end else begin
					res.oid = '0;
					res.st  = ST_EMPTY;
				end
			end
			OP_SWAP: begin
				bank_nx   = ~bank_q;
				active_nx = total_q;
			end
			OP_RETIRE: begin
				total_nx  = total_dec;
				active_nx = active_dec;
			end
			OP_CLEAR_ACT: begin
				active_nx = '0;
			end
			default: begin
			end
		endcase
		res.total  = total_nx;
		res.active = active_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NQ; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			bank_q   <= 1'b0;
			total_q  <= '0;
			active_q <= '0;
		end else if (fire) begin
			bank_q   <= bank_nx;
			total_q  <= total_nx;
			active_q <= active_nx;
			if (push_ok) begin
				tail_q[q_sel] <= ptr_inc(tail_q[q_sel]);
				fill_q[q_sel] <= fill_sel + 1'b1;
			end else if (pop_ok) begin
				head_q[q_sel] <= ptr_inc(head_q[q_sel]);
				fill_q[q_sel] <= fill_sel - 1'b1;
			end
		end
	end

endmodule

[src/active_expired_priority_runqueue_unit.sv]
`timescale 1ns / 1ps
// Active/expired priority run-queue unit: top level with input and result registers.
// Path: a beat is captured in the input register, handled by the queue control and
// held in the result register until the master side takes it.
// Throughput: one beat per cycle while the master side accepts results; the entry RAM has one write and one read port.
// Reset clears all queue pointers and fill counts, the bank select and both thread
// counters, and sets the demote threshold to 20; RAM contents are not cleared.
module active_expired_priority_runqueue_unit import aeprq_pkg::*; #(
	parameter int LEVELS      = LEVELS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode[2:0], thread_id[10:3], priority_req[14:11], exec_time[30:15], zero[31]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_thread_id[7:0], out_priority[11:8], status[13:12], total_threads[22:14],
	// active_threads[31:23]
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ID_W   = (ID_BITS < TID_W) ? ID_BITS : TID_W;
	localparam int ADDR_W = $clog2(2 * LEVELS * QUEUE_DEPTH);

	logic [THR_W-1:0]   demote_threshold_q;
	logic               valid_s1;
	opcode_t            op_s1;
	logic [TID_W-1:0]   tid_s1;
	logic [PRI_W-1:0]   pri_s1;
	logic [ETIME_W-1:0] et_s1;
	logic               valid_s2;
	aeprq_res_t         res_s2;
	aeprq_res_t         res;
	logic               adv_s1;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ID_W-1:0]    ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ID_W-1:0]    ram_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {16'b0, demote_threshold_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			demote_threshold_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			demote_threshold_q <= pwdata[THR_W-1:0];
		end
	end

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= opcode_t'(s_tdata[2:0]);
			tid_s1 <= s_tdata[10:3];
			pri_s1 <= s_tdata[14:11];
			et_s1  <= s_tdata[30:15];
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	aeprq_qctl #(
		.LEVELS      (LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_qctl (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (adv_s1),
		.op               (op_s1),
		.thread_id        (tid_s1),
		.priority_req     (pri_s1),
		.exec_time        (et_s1),
		.demote_threshold (demote_threshold_q),
		.res              (res),
		.ram_we           (ram_we),
		.ram_waddr        (ram_waddr),
		.ram_wdata        (ram_wdata),
		.ram_re           (ram_re),
		.ram_raddr        (ram_raddr)
	);

	aeprq_ram #(
		.WIDTH (ID_W),
		.DEPTH (2 * LEVELS * QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.active, res_s2.total, res_s2.st, res_s2.opri,
		res_s2.from_ram ? TID_W'(ram_rdata) : res_s2.oid};

endmodule

[src/aeprq_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the run-queue unit, attached to the top level by bind.
// Depends only on the top level's ports.
module aeprq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:12] != 2'd3)
		else $error("undefined status code");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:23] <= m_tdata[22:14])
		else $error("active count exceeds total count");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[13:12] == 2'd2) |-> m_tdata[11:0] == 12'd0)
		else $error("empty take reports a thread or level");

endmodule

bind active_expired_priority_runqueue_unit aeprq_checker u_aeprq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the active/expired priority run-queue unit.
// Drives the stream and APB ports, predicts every result beat and compares them.
// Depends on aeprq_pkg and active_expired_priority_runqueue_unit from src.
module tb_top;
	import aeprq_pkg::*;

	localparam int NQ          = 2 * LEVELS_DEF;
	localparam int COUNT_CAP   = (NQ * QUEUE_DEPTH_DEF < 511) ? NQ * QUEUE_DEPTH_DEF : 511;
	localparam int QUIET_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;

	localparam logic [OPC_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OPC_W-1:0] OP_SPARE_7 = 3'd7;
	localparam logic [2:0] ADDR_DEMOTE_THR  = 3'd0;

	typedef struct packed {
		logic [OPC_W-1:0]   opc;
		logic [TID_W-1:0]   tid;
		logic [PRI_W-1:0]   pri;
		logic [ETIME_W-1:0] et;
	} sched_req_t;

	typedef struct packed {
		logic [TID_W-1:0]   tid;
		logic [PRI_W-1:0]   pri;
		logic [STAT_W-1:0]  st;
		logic [COUNT_W-1:0] total;
		logic [COUNT_W-1:0] active;
	} sched_res_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predicted scheduler state.
	logic [TID_W-1:0] slot_id [NQ][QUEUE_DEPTH_DEF];
	int q_head [NQ] = '{default: 0};
	int q_tail [NQ] = '{default: 0};
	int q_fill [NQ] = '{default: 0};
	int bank_sel = 0;
	int n_total  = 0;
	int n_active = 0;
	logic [THR_W-1:0] demote_thr = THRESH_RESET;

	sched_res_t due_results [$];
	sched_res_t seen_res, want_res;
	int mismatches   = 0;
	int quiet_cycles = 0;
	int gap_pct      = 0;
	int stall_pct    = 0;

	active_expired_priority_runqueue_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int sat_up(int v);
		return (v < COUNT_CAP) ? v + 1 : v;
	endfunction

	function automatic int sat_down(int v);
		return (v > 0) ? v - 1 : 0;
	endfunction

	function automatic bit push_id(int q, logic [TID_W-1:0] id);
		if (q_fill[q] >= QUEUE_DEPTH_DEF)
			return 1'b0;
		slot_id[q][q_tail[q]] = id;
		q_tail[q] = (q_tail[q] + 1) % QUEUE_DEPTH_DEF;
		q_fill[q]++;
		return 1'b1;
	endfunction

	function automatic sched_res_t runq_step(sched_req_t r);
		sched_res_t res;
		int lvl, act_q, exp_q;
		bit taken;
		lvl = (r.pri >= LEVELS_DEF) ? LEVELS_DEF - 1 : int'(r.pri);
		act_q = bank_sel * LEVELS_DEF;
		exp_q = (bank_sel ^ 1) * LEVELS_DEF;
		res.tid = r.tid;
		res.pri = '0;
		res.st = ST_OK;
		taken = 1'b0;
		case (r.opc)
			OP_ADD_ACTIVE: begin
				res.pri = PRI_W'(lvl);
				if (push_id(act_q + lvl, r.tid)) begin
					n_total = sat_up(n_total);
					n_active = sat_up(n_active);
				end else begin
					res.st = ST_FULL;
				end
			end
			OP_ADD_EXPIRED: begin
				if (r.et > demote_thr && lvl + 2 <= LEVELS_DEF)
					lvl++;
				res.pri = PRI_W'(lvl);
				if (!push_id(exp_q + lvl, r.tid))
					res.st = ST_FULL;
				// The thread has left the active bank even when it is dropped.
				n_active = sat_down(n_active);
			end
			OP_TAKE: begin
				res.tid = '0;
				res.st = ST_EMPTY;
				for (int i = 0; i < LEVELS_DEF; i++) begin
					if (!taken && q_fill[act_q + i] != 0) begin
						res.tid = slot_id[act_q + i][q_head[act_q + i]];
						q_head[act_q + i] = (q_head[act_q + i] + 1) % QUEUE_DEPTH_DEF;
						q_fill[act_q + i]--;
						res.pri = PRI_W'(i);
						res.st = ST_OK;
						taken = 1'b1;
					end
				end
			end
			OP_SWAP: begin
				bank_sel ^= 1;
				n_active = n_total;
			end
			OP_RETIRE: begin
				n_total = sat_down(n_total);
				n_active = sat_down(n_active);
			end
			OP_CLEAR_ACT: begin
				n_active = 0;
			end
			default: begin
			end
		endcase
		res.total = COUNT_W'(n_total);
		res.active = COUNT_W'(n_active);
		return res;
	endfunction

	function automatic logic [ETIME_W-1:0] pick_etime();
		case ($urandom_range(5))
			0: return demote_thr;
			1: return (demote_thr == 16'hFFFF) ? demote_thr : demote_thr + 16'd1;
			2: return (demote_thr == 16'h0000) ? demote_thr : demote_thr - 16'd1;
			3: return 16'h0000;
			4: return 16'hFFFF;
			default: return ETIME_W'($urandom);
		endcase
	endfunction

	function automatic logic [PRI_W-1:0] pick_level();
		return ($urandom_range(7) == 0) ? PRI_W'($urandom_range(15, 9)) :
			PRI_W'($urandom_range(8));
	endfunction

	task automatic send_sched_op(logic [OPC_W-1:0] opc, logic [TID_W-1:0] tid,
			logic [PRI_W-1:0] pri, logic [ETIME_W-1:0] et);
		sched_req_t r;
		r.opc = opc;
		r.tid = tid;
		r.pri = pri;
		r.et = et;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, r.et, r.pri, r.tid, r.opc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		due_results.push_back(runq_step(r));
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		demote_thr = value[THR_W-1:0];
	endtask

	task automatic test_directed_ops();
		gap_pct = 0;
		stall_pct = 0;
		send_sched_op(OP_TAKE, 8'h33, 4'd0, 16'd0);
		send_sched_op(OP_RETIRE, 8'h01, 4'd0, 16'd0);
		send_sched_op(OP_CLEAR_ACT, 8'h02, 4'd0, 16'd0);
		send_sched_op(OP_ADD_EXPIRED, 8'h11, 4'd3, 16'd5);
		send_sched_op(OP_ADD_ACTIVE, 8'hFF, 4'd0, 16'hFFFF);
		send_sched_op(OP_ADD_ACTIVE, 8'h00, 4'd15, 16'd0);
		send_sched_op(OP_ADD_ACTIVE, 8'h5A, 4'd8, 16'd0);
		repeat (4) send_sched_op(OP_TAKE, 8'hA5, 4'd15, 16'hFFFF);
		send_sched_op(OP_SPARE_6, 8'h77, 4'd2, 16'd9);
		send_sched_op(OP_SPARE_7, 8'hC3, 4'd15, 16'hFFFF);
		send_sched_op(OP_ADD_EXPIRED, 8'h21, 4'd7, 16'd20);
		send_sched_op(OP_ADD_EXPIRED, 8'h22, 4'd7, 16'd21);
		send_sched_op(OP_ADD_EXPIRED, 8'h23, 4'd8, 16'hFFFF);
		send_sched_op(OP_ADD_EXPIRED, 8'h24, 4'd15, 16'hFFFF);
		send_sched_op(OP_ADD_EXPIRED, 8'h25, 4'd0, 16'd21);
		send_sched_op(OP_SWAP, 8'h00, 4'd0, 16'd0);
		repeat (3) send_sched_op(OP_TAKE, 8'h00, 4'd0, 16'd0);
		send_sched_op(OP_CLEAR_ACT, 8'hFF, 4'd15, 16'hFFFF);
		send_sched_op(OP_RETIRE, 8'h80, 4'd1, 16'd0);
	endtask

	task automatic test_demote_threshold();
		wait_results_done();
		cfg_write(ADDR_DEMOTE_THR, 32'd0);
		send_sched_op(OP_ADD_EXPIRED, 8'h41, 4'd2, 16'd0);
		send_sched_op(OP_ADD_EXPIRED, 8'h42, 4'd2, 16'd1);
		wait_results_done();
		cfg_write(ADDR_DEMOTE_THR, 32'h0000_FFFF);
		send_sched_op(OP_ADD_EXPIRED, 8'h43, 4'd2, 16'hFFFF);
		send_sched_op(OP_ADD_EXPIRED, 8'h44, 4'd0, 16'hFFFE);
	endtask

	// Bursts of adds to one level fill queues, runs of takes drain them to empty,
	// and single items with every field random make up the noise.
	task automatic test_random_phase(int gap, int stall, logic [THR_W-1:0] thr, int n_items);
		int sent, kind, len;
		bit first;
		logic [PRI_W-1:0] lvl;
		logic [OPC_W-1:0] opc;
		wait_results_done();
		cfg_write(ADDR_DEMOTE_THR, {16'd0, thr});
		gap_pct = gap;
		stall_pct = stall;
		sent = 0;
		first = 1'b1;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			len = 1;
			if (first) begin
				lvl = pick_level();
				len = $urandom_range(20, 17);
				repeat (len) send_sched_op(OP_ADD_ACTIVE, TID_W'($urandom), lvl, pick_etime());
				repeat (len) send_sched_op(OP_ADD_EXPIRED, TID_W'($urandom), lvl, 16'd0);
				len = 2 * len;
			end else if (kind < 30) begin
				len = $urandom_range(20, 1);
				lvl = pick_level();
				opc = ($urandom_range(3) == 0) ? OP_ADD_EXPIRED : OP_ADD_ACTIVE;
				repeat (len) send_sched_op(opc, TID_W'($urandom), lvl, pick_etime());
			end else if (kind < 55) begin
				len = $urandom_range(20, 1);
				repeat (len) send_sched_op(OP_TAKE, TID_W'($urandom), PRI_W'($urandom),
					ETIME_W'($urandom));
			end else if (kind < 62) begin
				send_sched_op(OP_SWAP, TID_W'($urandom), PRI_W'($urandom), ETIME_W'($urandom));
			end else if (kind < 64) begin
				wait_results_done();
				len = 0;
			end else begin
				send_sched_op(OPC_W'($urandom_range(7)), TID_W'($urandom),
					PRI_W'($urandom_range(15)), ETIME_W'($urandom));
			end
			first = 1'b0;
			sent += len;
		end
	endtask

	task automatic test_counter_ceiling();
		while (n_total < COUNT_CAP) begin
			send_sched_op(OP_ADD_ACTIVE, TID_W'($urandom), pick_level(), ETIME_W'($urandom));
			send_sched_op(OP_TAKE, TID_W'($urandom), PRI_W'($urandom), ETIME_W'($urandom));
		end
		repeat (3) begin
			send_sched_op(OP_ADD_ACTIVE, TID_W'($urandom), pick_level(), ETIME_W'($urandom));
			send_sched_op(OP_TAKE, TID_W'($urandom), PRI_W'($urandom), ETIME_W'($urandom));
		end
		send_sched_op(OP_SWAP, TID_W'($urandom), PRI_W'($urandom), ETIME_W'($urandom));
		repeat (2) send_sched_op(OP_ADD_ACTIVE, TID_W'($urandom), pick_level(), 16'd0);
		send_sched_op(OP_TAKE, TID_W'($urandom), PRI_W'($urandom), ETIME_W'($urandom));
		send_sched_op(OP_RETIRE, TID_W'($urandom), PRI_W'($urandom), ETIME_W'($urandom));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_res.tid = m_tdata[7:0];
			seen_res.pri = m_tdata[11:8];
			seen_res.st = m_tdata[13:12];
			seen_res.total = m_tdata[22:14];
			seen_res.active = m_tdata[31:23];
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("Result beat with nothing outstanding: %h", m_tdata);
			end else begin
				want_res = due_results.pop_front();
				if (seen_res !== want_res) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"Mismatch (expected/actual): thread %0d/%0d level %0d/%0d ",
							"status %0d/%0d total %0d/%0d active %0d/%0d"},
							want_res.tid, seen_res.tid, want_res.pri, seen_res.pri,
							want_res.st, seen_res.st, want_res.total, seen_res.total,
							want_res.active, seen_res.active);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_demote_threshold();
		test_random_phase(0, 0, THRESH_RESET, 140);
		test_random_phase(78, 0, 16'd0, 140);
		test_random_phase(0, 78, 16'hFFFF, 140);
		test_random_phase(11, 11, THR_W'($urandom), 140);
		test_counter_ceiling();
		wait_results_done();
		repeat (6) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
src/aeprq_pkg.sv
src/aeprq_ram.sv
src/aeprq_qctl.sv
src/active_expired_priority_runqueue_unit.sv
src/aeprq_checker.sv
dv/tb_top.sv
